[hdl/apr_pkg.sv]
// Shared constants and types for the box push-out resolver.
// No dependencies; imported by the front and back units.
`timescale 1ns / 1ps

package apr_pkg;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_RESOLVE = 1'b1
  } kind_t;

endpackage

[hdl/apr_channels.sv]
// Valid/ready channel interfaces for the box push-out resolver.
// Depends on nothing; widths come from the instantiating module.
`timescale 1ns / 1ps

interface apr_in_if #(
  parameter int COORD_BITS = 20,
  parameter int SIZE_BITS  = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic        [SIZE_BITS-1:0]  rect_w;
  logic        [SIZE_BITS-1:0]  rect_h;

  modport source (output valid, action, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink (input valid, action, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface apr_out_if #(
  parameter int COORD_BITS = 20
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         hit;

  modport source (output valid, out_x, out_y, hit, input ready);
  modport sink (input valid, out_x, out_y, hit, output ready);
endinterface

[hdl/apr_front.sv]
// Front unit: accepts input items, classifies them and computes the doubled
// obstacle centres. Depends on apr_pkg and apr_in_if.
`timescale 1ns / 1ps

module apr_front #(
  parameter int COORD_BITS = 20,
  parameter int SIZE_BITS  = 16,
  parameter int CTR_BITS   = 34,
  parameter int PAY_BITS   = 141
) (
  apr_in_if.sink               items,
  input  logic                 full,
  output logic                 push,
  output logic [PAY_BITS-1:0]  push_data
);
  import apr_pkg::*;

  kind_t                      kind;
  logic signed [CTR_BITS-1:0] cen_x;
  logic signed [CTR_BITS-1:0] cen_y;

  always_comb begin
    kind  = (items.action == ACT_LOAD) ? KIND_LOAD : KIND_RESOLVE;
    cen_x = (CTR_BITS'(items.rect_x) <<< 1) + $signed(CTR_BITS'(items.rect_w));
    cen_y = (CTR_BITS'(items.rect_y) <<< 1) + $signed(CTR_BITS'(items.rect_h));
  end

  assign items.ready = !full;
  assign push        = items.valid && !full;
  assign push_data   = {kind, items.rect_x, items.rect_y, items.rect_w, items.rect_h,
                        cen_x, cen_y};

endmodule

[hdl/apr_queue.sv]
// Small register queue that decouples the front and back units.
// No dependencies.
`timescale 1ns / 1ps

module apr_queue #(
  parameter int WIDTH = 141,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/apr_back.sv]
// Back unit: holds the moving box, resolves overlaps and drives the result
// register. Depends on apr_pkg and apr_out_if.
`timescale 1ns / 1ps

module apr_back #(
  parameter int COORD_BITS = 20,
  parameter int SIZE_BITS  = 16,
  parameter int CTR_BITS   = 34,
  parameter int PAY_BITS   = 141
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  logic [PAY_BITS-1:0] pop_data,
  output logic                pop,
  apr_out_if.source           results
);
  import apr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int SW = SIZE_BITS;
  localparam int DW = CTR_BITS + 1;

  kind_t                      q_kind;
  logic signed [CW-1:0]       q_x;
  logic signed [CW-1:0]       q_y;
  logic        [SW-1:0]       q_w;
  logic        [SW-1:0]       q_h;
  logic signed [CTR_BITS-1:0] q_cx;
  logic signed [CTR_BITS-1:0] q_cy;

  logic signed [CW-1:0] box_x;
  logic signed [CW-1:0] box_y;
  logic        [SW-1:0] box_w;
  logic        [SW-1:0] box_h;
  logic signed [CW-1:0] box_x_next;
  logic signed [CW-1:0] box_y_next;
  logic        [SW-1:0] box_w_next;
  logic        [SW-1:0] box_h_next;

  logic signed [CTR_BITS-1:0] bcx;
  logic signed [CTR_BITS-1:0] bcy;
  logic signed [DW-1:0]       dx2;
  logic signed [DW-1:0]       dy2;
  logic        [DW-1:0]       adx;
  logic        [DW-1:0]       ady;
  logic        [DW-1:0]       ws2;
  logic        [DW-1:0]       hs2;
  logic        [DW-1:0]       px2;
  logic        [DW-1:0]       py2;
  logic        [DW-1:0]       push_x;
  logic        [DW-1:0]       push_y;
  logic signed [DW-1:0]       nx;
  logic signed [DW-1:0]       ny;
  logic                       overlap;
  logic                       hit_next;

  function automatic logic signed [CW-1:0] sat(input logic signed [DW-1:0] v);
    logic [DW-CW:0] top;
    top = v[DW-1:CW-1];
    if ((top == '0) || (top == '1)) begin
      sat = v[CW-1:0];
    end else if (v[DW-1]) begin
      sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  assign q_kind = kind_t'(pop_data[PAY_BITS-1]);
  assign {q_x, q_y, q_w, q_h, q_cx, q_cy} = pop_data[PAY_BITS-2:0];

  assign pop = pop_valid && (!results.valid || results.ready);

  always_comb begin
    bcx     = (CTR_BITS'(box_x) <<< 1) + $signed(CTR_BITS'(box_w));
    bcy     = (CTR_BITS'(box_y) <<< 1) + $signed(CTR_BITS'(box_h));
    dx2     = DW'(bcx) - DW'(q_cx);
    dy2     = DW'(bcy) - DW'(q_cy);
    adx     = dx2[DW-1] ? DW'(-dx2) : DW'(dx2);
    ady     = dy2[DW-1] ? DW'(-dy2) : DW'(dy2);
    ws2     = DW'(box_w) + DW'(q_w);
    hs2     = DW'(box_h) + DW'(q_h);
    overlap = (adx < ws2) && (ady < hs2);
    px2     = ws2 - adx;
    py2     = hs2 - ady;
    push_x  = (px2 + 1'b1) >> 1;
    push_y  = (py2 + 1'b1) >> 1;
    nx      = (!dx2[DW-1] && (dx2 != '0)) ? DW'(box_x) + $signed(push_x)
                                          : DW'(box_x) - $signed(push_x);
    ny      = (!dy2[DW-1] && (dy2 != '0)) ? DW'(box_y) + $signed(push_y)
                                          : DW'(box_y) - $signed(push_y);

    box_x_next = box_x;
    box_y_next = box_y;
    box_w_next = box_w;
    box_h_next = box_h;
    hit_next   = 1'b0;
    if (q_kind == KIND_LOAD) begin
      box_x_next = q_x;
      box_y_next = q_y;
      box_w_next = q_w;
      box_h_next = q_h;
    end else if (overlap) begin
      hit_next = 1'b1;
      if (px2 < py2) begin
        box_x_next = sat(nx);
      end else begin
        box_y_next = sat(ny);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x         <= '0;
      box_y         <= '0;
      box_w         <= '0;
      box_h         <= '0;
      results.valid <= 1'b0;
    end else begin
      if (pop) begin
        box_x         <= box_x_next;
        box_y         <= box_y_next;
        box_w         <= box_w_next;
        box_h         <= box_h_next;
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.out_x <= box_x_next;
      results.out_y <= box_y_next;
      results.hit   <= hit_next;
    end
  end

endmodule

[hdl/aabb_pushout_resolver.sv]
// Top level of the box push-out resolver.
// Depends on apr_pkg, apr_channels, apr_front, apr_queue and apr_back.
`timescale 1ns / 1ps

// The block accepts one item per cycle while its queue is not full and returns
// exactly one result per item, in order. A load item replaces the moving box; an
// obstacle item that overlaps the box pushes it out along the axis of smaller
// penetration and reports a hit. A result is presented once its item has been
// accepted into the two-entry queue behind the front unit and then moved by the
// back unit into its result register. The stored box in the back unit is
// updated on each move from the queue, which sets the sustained rate of one
// item per cycle while the result side is not stalled. Either side may stall
// without losing items.

module aabb_pushout_resolver #(
  parameter int COORD_BITS = 20,
  parameter int SIZE_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  apr_in_if.sink    items,
  apr_out_if.source results
);
  localparam int CTR_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
  localparam int PAY_BITS = 1 + 2 * COORD_BITS + 2 * SIZE_BITS + 2 * CTR_BITS;

  logic                push;
  logic [PAY_BITS-1:0] push_data;
  logic                full;
  logic                pop;
  logic [PAY_BITS-1:0] pop_data;
  logic                pop_valid;

  apr_front #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS),
    .CTR_BITS   (CTR_BITS),
    .PAY_BITS   (PAY_BITS)
  ) u_front (
    .items     (items),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  apr_queue #(
    .WIDTH (PAY_BITS),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .pop_valid (pop_valid)
  );

  apr_back #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS),
    .CTR_BITS   (CTR_BITS),
    .PAY_BITS   (PAY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .results   (results)
  );

endmodule

[sim/aabb_pushout_resolver_tb.sv]
// Self-checking testbench for the box push-out resolver: directed table, then random items.
// Depends on apr_pkg, apr_channels and the aabb_pushout_resolver top level.
`timescale 1ns / 1ps

module aabb_pushout_resolver_tb;
  import apr_pkg::*;

  localparam int COORD_BITS   = 20;
  localparam int SIZE_BITS    = 16;
  localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam int LIMIT_CYCLES = 200000;
  localparam int N_DIRECTED   = 23;

  typedef struct packed {
    logic                         act;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [SIZE_BITS-1:0]  w;
    logic        [SIZE_BITS-1:0]  h;
    logic                         typed;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic                         ehit;
  } box_row_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         hit;
  } box_pos_t;

  logic clk;
  logic rst;

  apr_in_if #(.COORD_BITS(COORD_BITS), .SIZE_BITS(SIZE_BITS)) items_ch ();
  apr_out_if #(.COORD_BITS(COORD_BITS)) results_ch ();

  aabb_pushout_resolver #(
    .COORD_BITS(COORD_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_ch),
    .results(results_ch)
  );

  box_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{ACT_RESOLVE, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0},
    '{ACT_LOAD, 524287, -524288, 65535, 65535, 1'b1, 524287, -524288, 1'b0},
    '{ACT_LOAD, -524288, 524287, 0, 0, 1'b1, -524288, 524287, 1'b0},
    '{ACT_RESOLVE, -524288, 524287, 0, 0, 1'b1, -524288, 524287, 1'b0},
    '{ACT_LOAD, 0, 0, 32, 32, 1'b1, 0, 0, 1'b0},
    '{ACT_RESOLVE, 32, 0, 32, 32, 1'b1, 0, 0, 1'b0},
    '{ACT_RESOLVE, 0, -32, 32, 32, 1'b1, 0, 0, 1'b0},
    '{ACT_RESOLVE, 32, 16, 0, 0, 1'b1, 0, 0, 1'b0},
    '{ACT_RESOLVE, 16, 16, 0, 0, 1'b0, 0, 0, 1'b0},
    '{ACT_RESOLVE, 24, -16, 32, 32, 1'b0, 0, 0, 1'b0},
    '{ACT_RESOLVE, 5, -16, 33, 32, 1'b0, 0, 0, 1'b0},
    '{ACT_RESOLVE, 0, -40, 32, 32, 1'b0, 0, 0, 1'b0},
    '{ACT_LOAD, 524000, 0, 65535, 65535, 1'b1, 524000, 0, 1'b0},
    '{ACT_RESOLVE, 523990, 0, 65535, 65535, 1'b1, 524287, 0, 1'b1},
    '{ACT_LOAD, -524288, 0, 65535, 65535, 1'b1, -524288, 0, 1'b0},
    '{ACT_RESOLVE, -524278, 0, 65535, 65535, 1'b1, -524288, 0, 1'b1},
    '{ACT_LOAD, 0, -524288, 65535, 65535, 1'b1, 0, -524288, 1'b0},
    '{ACT_RESOLVE, 0, -524280, 65535, 65535, 1'b1, 0, -524288, 1'b1},
    '{ACT_LOAD, 0, 524287, 65535, 65535, 1'b1, 0, 524287, 1'b0},
    '{ACT_RESOLVE, 0, 524280, 65535, 65535, 1'b1, 0, 524287, 1'b1},
    '{ACT_LOAD, 100, 100, 48, 16, 1'b1, 100, 100, 1'b0},
    '{ACT_RESOLVE, 100, 100, 48, 16, 1'b0, 0, 0, 1'b0},
    '{ACT_RESOLVE, -524288, -524288, 65535, 65535, 1'b0, 0, 0, 1'b0}
  };

  // Shadow of the moving box, advanced once per accepted item.
  logic signed [COORD_BITS-1:0] box_x = '0;
  logic signed [COORD_BITS-1:0] box_y = '0;
  logic        [SIZE_BITS-1:0]  box_w = '0;
  logic        [SIZE_BITS-1:0]  box_h = '0;

  box_row_t rows_in_flight [$];
  box_pos_t expected_positions [$];

  int     sent_count      = 0;
  int     results_checked = 0;
  int     load_count      = 0;
  int     obstacle_count  = 0;
  int     hit_count       = 0;
  int     failures        = 0;
  int     cycle_count     = 0;
  int     send_idle_pct   = 0;
  int     recv_stall_pct  = 0;
  logic   results_held    = 1'b0;

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic box_pos_t push_box_out(input box_row_t r);
    box_pos_t res;
    longint dx2, dy2, ws2, hs2, adx, ady, px2, py2, step;
    res.hit = 1'b0;
    if (r.act == ACT_LOAD) begin
      box_x = r.x;
      box_y = r.y;
      box_w = r.w;
      box_h = r.h;
    end else begin
      dx2 = (2 * longint'(box_x) + longint'(box_w)) - (2 * longint'(r.x) + longint'(r.w));
      dy2 = (2 * longint'(box_y) + longint'(box_h)) - (2 * longint'(r.y) + longint'(r.h));
      ws2 = longint'(box_w) + longint'(r.w);
      hs2 = longint'(box_h) + longint'(r.h);
      adx = (dx2 < 0) ? -dx2 : dx2;
      ady = (dy2 < 0) ? -dy2 : dy2;
      if (adx < ws2 && ady < hs2) begin
        px2 = ws2 - adx;
        py2 = hs2 - ady;
        res.hit = 1'b1;
        if (px2 < py2) begin
          step = (px2 + 1) / 2;
          box_x = COORD_BITS'(clamp_coord((dx2 > 0) ? box_x + step : box_x - step));
        end else begin
          step = (py2 + 1) / 2;
          box_y = COORD_BITS'(clamp_coord((dy2 > 0) ? box_y + step : box_y - step));
        end
      end
    end
    res.x = box_x;
    res.y = box_y;
    return res;
  endfunction

  // Most obstacles are placed around the current box so that pushes are frequent.
  function automatic box_row_t random_row();
    box_row_t r;
    logic [31:0] raw;
    int pick;
    longint max_w, max_h, reach_x, reach_y;
    r = '0;
    pick = $urandom_range(99);
    if (pick < 12) begin
      r.act = ACT_LOAD;
      raw = $urandom();
      r.x = ($urandom_range(99) < 30) ? raw[COORD_BITS-1:0]
                                      : COORD_BITS'($urandom_range(8192) - 4096);
      raw = $urandom();
      r.y = ($urandom_range(99) < 30) ? raw[COORD_BITS-1:0]
                                      : COORD_BITS'($urandom_range(8192) - 4096);
      r.w = ($urandom_range(99) < 15) ? SIZE_BITS'($urandom_range(65535))
                                      : SIZE_BITS'($urandom_range(1024));
      r.h = ($urandom_range(99) < 20) ? r.w :
            (($urandom_range(99) < 15) ? SIZE_BITS'($urandom_range(65535))
                                       : SIZE_BITS'($urandom_range(1024)));
    end else if (pick < 27) begin
      r.act = ACT_RESOLVE;
      raw = $urandom();
      r.x = raw[COORD_BITS-1:0];
      raw = $urandom();
      r.y = raw[COORD_BITS-1:0];
      raw = $urandom();
      r.w = raw[SIZE_BITS-1:0];
      r.h = raw[31:32-SIZE_BITS];
    end else if (pick < 35) begin
      r.act = ACT_RESOLVE;
      r.x = box_x;
      r.y = box_y;
      r.w = box_w;
      r.h = ($urandom_range(1)) ? box_h : box_w;
    end else begin
      r.act = ACT_RESOLVE;
      max_w = 2 * longint'(box_w) + 64;
      max_h = 2 * longint'(box_h) + 64;
      r.w = SIZE_BITS'($urandom_range(32'((max_w > 65535) ? 65535 : max_w)));
      r.h = SIZE_BITS'($urandom_range(32'((max_h > 65535) ? 65535 : max_h)));
      reach_x = (longint'(box_w) + longint'(r.w)) / 2 + 8;
      reach_y = (longint'(box_h) + longint'(r.h)) / 2 + 8;
      r.x = COORD_BITS'(clamp_coord((2 * longint'(box_x) + longint'(box_w) - longint'(r.w)) / 2
                        + longint'($urandom_range(32'(2 * reach_x))) - reach_x));
      r.y = COORD_BITS'(clamp_coord((2 * longint'(box_y) + longint'(box_h) - longint'(r.h)) / 2
                        + longint'($urandom_range(32'(2 * reach_y))) - reach_y));
    end
    return r;
  endfunction

  task automatic send_item(input box_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rows_in_flight.push_back(r);
    items_ch.valid  <= 1'b1;
    items_ch.action <= r.act;
    items_ch.rect_x <= r.x;
    items_ch.rect_y <= r.y;
    items_ch.rect_w <= r.w;
    items_ch.rect_h <= r.h;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_item(random_row());
  endtask

  task automatic wait_drained();
    items_ch.valid <= 1'b0;
    while (results_checked != sent_count) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, sent_count - results_checked);
      $display("aabb_pushout_resolver test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    results_ch.ready <= !results_held && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    box_row_t row;
    box_pos_t want;
    box_pos_t got;
    if (!rst) begin
      if (results_ch.valid && results_ch.ready) begin
        got = '{results_ch.out_x, results_ch.out_y, results_ch.hit};
        results_checked++;
        if (expected_positions.size() == 0) begin
          $error("Result with no item waiting: out_x %0d, out_y %0d, hit %0b",
                 got.x, got.y, got.hit);
          failures++;
        end else begin
          want = expected_positions.pop_front();
          if (got.x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, got.x);
            failures++;
          end
          if (got.y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, got.y);
            failures++;
          end
          if (got.hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, got.hit);
            failures++;
          end
          if (got.hit === 1'b1) hit_count++;
        end
      end
      if (items_ch.valid && items_ch.ready) begin
        row = rows_in_flight.pop_front();
        want = push_box_out(row);
        if (row.typed) want = '{row.ex, row.ey, row.ehit};
        expected_positions.push_back(want);
        if (row.act == ACT_LOAD) load_count++;
        else obstacle_count++;
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    items_ch.valid   <= 1'b0;
    items_ch.action  <= ACT_LOAD;
    items_ch.rect_x  <= '0;
    items_ch.rect_y  <= '0;
    items_ch.rect_w  <= '0;
    items_ch.rect_h  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_item(directed_rows[i]);
    wait_drained();

    // The long hold fills the block so its input stalls while items keep coming.
    fork
      begin
        results_held <= 1'b1;
        repeat (150) @(posedge clk);
        results_held <= 1'b0;
      end
      send_random(120);
    join
    send_random(230);
    wait_drained();

    send_idle_pct = 65;
    send_random(350);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 65;
    send_random(350);
    wait_drained();

    send_idle_pct = 7;
    recv_stall_pct = 7;
    send_random(375);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d items: %0d box loads and %0d obstacle tests, %0d of them pushes.",
             sent_count, load_count, obstacle_count, hit_count);
    $display("Phases ran with no idling, a long result hold, sender gaps, result stalls, both.");
    if (failures == 0) begin
      $display("aabb_pushout_resolver test passed");
    end else begin
      $display("aabb_pushout_resolver test failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/apr_pkg.sv
hdl/apr_channels.sv
hdl/apr_front.sv
hdl/apr_queue.sv
hdl/apr_back.sv
hdl/aabb_pushout_resolver.sv
sim/aabb_pushout_resolver_tb.sv
